// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL file of the SIMON cipher block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, ignored while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/simon_pkg.sv -----
// Types, constants and round functions of the SIMON 128-bit cipher block.
`default_nettype none

package simon_pkg;

    localparam int RK_DEPTH = 72;

    typedef logic [63:0] t_word;

    // command word
    typedef struct packed {
        logic  cmd;
        t_word block_x;
        t_word block_y;
    } t_simon_in;

    // result word
    typedef struct packed {
        t_word out_x;
        t_word out_y;
    } t_simon_out;

    // operation codes
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE = 3'd0,
        CFG_KEY0 = 3'd1,
        CFG_KEY1 = 3'd2,
        CFG_KEY2 = 3'd3,
        CFG_KEY3 = 3'd4
    } t_cfg_idx;

    // key size selects
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam t_word RK_CONST = 64'hffff_ffff_ffff_fffc;

    // round counts per key size
    localparam logic [6:0] ROUNDS_128 = 7'd68;
    localparam logic [6:0] ROUNDS_192 = 7'd69;
    localparam logic [6:0] ROUNDS_256 = 7'd72;

    // z sequences: tail bits above the 64 low bits
    localparam logic [71:0] Z_SEQ_128 = {6'd0, 2'd1, 64'h7369_f885_192c_0ef5};
    localparam logic [71:0] Z_SEQ_192 = {6'd0, 2'd2, 64'hfc2c_e512_07a6_35db};
    localparam logic [71:0] Z_SEQ_256 = {6'd0, 2'd2, 64'hfdc9_4c3a_046d_678b};

    function automatic t_word rotl(input t_word v, input int n);
        rotl = (v << n) | (v >> (64 - n));
    endfunction

    function automatic t_word rotr(input t_word v, input int n);
        rotr = (v >> n) | (v << (64 - n));
    endfunction

    // round function f(x)
    function automatic t_word mix(input t_word v);
        mix = (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
    endfunction

    function automatic logic z_bit(input logic [1:0] sel, input logic [6:0] j);
        case (sel)
            KS_128:  z_bit = Z_SEQ_128[j];
            KS_192:  z_bit = Z_SEQ_192[j];
            default: z_bit = Z_SEQ_256[j];
        endcase
    endfunction

    function automatic logic [6:0] rounds_of(input logic [1:0] sel);
        case (sel)
            KS_128:  rounds_of = ROUNDS_128;
            KS_192:  rounds_of = ROUNDS_192;
            default: rounds_of = ROUNDS_256;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- sv/simon_128_block_cipher.sv -----
// SIMON 128-bit block cipher with 128/192/256-bit key and a round-key memory.
//
// One block at a time. A command is taken when start is high and busy is low.
// With the round keys in place, a block runs n rounds from the start edge
// to the result strobe, n being 68, 69 or 72 for a 128, 192 or 256-bit key:
// a prime state starts the round-key memory read, then one round per cycle
// is fed by that single read port. After a mode or key register write the
// next command first runs the key schedule, writing one round key per cycle
// into the memory. The result is on o_res for exactly one
// cycle under o_res_valid and cannot be held off; busy is already low in that
// cycle, so the next command may start there. Configuration words are taken
// only while the core is idle (o_cfg_ready follows !busy). Key size code 3
// acts as 256.
`default_nettype none

module simon_128_block_cipher #(
    parameter int MAX_ROUNDS = simon_pkg::RK_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire simon_pkg::t_simon_in  i_blk,
    // result channel
    output logic                       o_res_valid,
    output simon_pkg::t_simon_out      o_res,
    // configuration channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [63:0]           i_cfg_data
);
    import simon_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_ROUNDS);
    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPAND = 4'b0010,
        ST_PREP   = 4'b0100,
        ST_ROUND  = 4'b1000
    } t_state;

    // registers
    t_state             r_state, n_state;
    logic               r_keys_ready, n_keys_ready;
    logic [1:0]         r_mode;
    t_word              r_key [4];
    t_word              r_win [4], n_win [4];
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_cmd, n_cmd;
    t_word              r_x, n_x, r_y, n_y;
    logic               r_res_valid, n_res_valid;
    t_simon_out         r_res, n_res;
    t_word              r_rk;

    // round-key memory
    t_word              mem_rk [MAX_ROUNDS];

    logic               wr_en;
    t_word              wr_data;
    logic               rd_en;
    logic [1:0]         ks_sel;
    logic [CNT_W-1:0]   n_rounds;
    logic [IDX_W-1:0]   first_idx;
    logic [IDX_W-1:0]   key_words;
    logic [1:0]         init_sel;
    logic [1:0]         back_sel;
    logic [6:0]         z_pos;
    t_word              sched_key;
    t_word              enc_x, dec_y;
    logic               accept;
    logic               cmd_sel;
    logic               cfg_we;

    assign ks_sel     = r_mode[1] ? KS_256 : r_mode;
    assign n_rounds   = CNT_W'(rounds_of(ks_sel));
    assign key_words  = IDX_W'(ks_sel) + IDX_W'(2);
    assign init_sel   = 2'(ks_sel + 2'd1 - r_idx[1:0]);
    assign back_sel   = 2'(ks_sel + 2'd1);
    assign z_pos      = 7'(r_idx - key_words);
    assign accept     = start && (r_state == ST_IDLE);
    assign cmd_sel    = (r_state == ST_IDLE) ? i_blk.cmd : r_cmd;
    assign cfg_we     = i_cfg_valid && o_cfg_ready;

    // first round key address: bottom for encryption, top for decryption
    always_comb begin
        if (cmd_sel == CMD_DEC) begin
            first_idx = IDX_W'(n_rounds - CNT_W'(1));
        end else begin
            first_idx = '0;
        end
    end

    // key schedule word from the window of recent round keys
    always_comb begin
        sched_key = RK_CONST ^ t_word'(z_bit(ks_sel, z_pos)) ^ r_win[back_sel]
                  ^ rotr(r_win[0], 3) ^ rotr(r_win[0], 4);
        if (ks_sel == KS_256) begin
            sched_key = sched_key ^ r_win[2] ^ rotr(r_win[2], 1);
        end
    end

    // one Feistel round each way
    assign enc_x = r_y ^ mix(r_x) ^ r_rk;
    assign dec_y = r_x ^ mix(r_y) ^ r_rk;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_keys_ready = r_keys_ready;
        n_win        = r_win;
        n_idx        = r_idx;
        n_left       = r_left;
        n_cmd        = r_cmd;
        n_x          = r_x;
        n_y          = r_y;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        wr_en        = 1'b0;
        wr_data      = sched_key;
        rd_en        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd = i_blk.cmd;
                    n_x   = i_blk.block_x;
                    n_y   = i_blk.block_y;
                    if (r_keys_ready) begin
                        n_idx   = first_idx;
                        n_left  = n_rounds;
                        n_state = ST_PREP;
                    end else begin
                        n_win   = r_key;
                        n_idx   = '0;
                        n_state = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND: begin
                wr_en = 1'b1;
                if (r_idx < key_words) begin
                    wr_data = r_key[init_sel];
                end else begin
                    n_win[3] = r_win[2];
                    n_win[2] = r_win[1];
                    n_win[1] = r_win[0];
                    n_win[0] = sched_key;
                end
                if (CNT_W'(r_idx) == n_rounds - CNT_W'(1)) begin
                    n_keys_ready = 1'b1;
                    n_idx        = first_idx;
                    n_left       = n_rounds;
                    n_state      = ST_PREP;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_PREP: begin
                rd_en   = 1'b1;
                n_idx   = (r_cmd == CMD_DEC) ? r_idx - IDX_W'(1) : r_idx + IDX_W'(1);
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_cmd == CMD_DEC) begin
                    n_x = r_y;
                    n_y = dec_y;
                end else begin
                    n_x = enc_x;
                    n_y = r_x;
                end
                n_left = r_left - CNT_W'(1);
                n_idx  = (r_cmd == CMD_DEC) ? r_idx - IDX_W'(1) : r_idx + IDX_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_res.out_x = n_x;
                    n_res.out_y = n_y;
                    n_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // any register write invalidates the schedule
        if (cfg_we && (i_cfg_index == CFG_MODE || i_cfg_index == CFG_KEY0
                || i_cfg_index == CFG_KEY1 || i_cfg_index == CFG_KEY2
                || i_cfg_index == CFG_KEY3)) begin
            n_keys_ready = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_keys_ready <= 1'b0;
            r_res_valid  <= 1'b0;
            r_idx        <= '0;
            r_left       <= '0;
        end else begin
            r_state      <= n_state;
            r_keys_ready <= n_keys_ready;
            r_res_valid  <= n_res_valid;
            r_idx        <= n_idx;
            r_left       <= n_left;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= KS_128;
            r_key  <= '{default: '0};
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode   <= i_cfg_data[1:0];
                CFG_KEY0: r_key[0] <= i_cfg_data;
                CFG_KEY1: r_key[1] <= i_cfg_data;
                CFG_KEY2: r_key[2] <= i_cfg_data;
                CFG_KEY3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_cmd <= n_cmd;
        r_x   <= n_x;
        r_y   <= n_y;
        r_res <= n_res;
    end

    // round-key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_rk[r_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rk <= mem_rk[r_idx];
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // checks
    `ASSERT_NEXT(a_last_round_strobes, i_clk, i_rst_n,
        (r_state == ST_ROUND) && (r_left == CNT_W'(1)), o_res_valid)
    `ASSERT_IMPL(a_round_count_live, i_clk, i_rst_n,
        r_state == ST_ROUND, r_left != '0)
    `ASSERT_NEXT(a_stale_keys_expand, i_clk, i_rst_n,
        start && !busy && !r_keys_ready, r_state == ST_EXPAND)
    `ASSERT_NEXT(a_cfg_clears_ready, i_clk, i_rst_n,
        cfg_we && (i_cfg_index == CFG_MODE || i_cfg_index == CFG_KEY3),
        !r_keys_ready)

endmodule

`default_nettype wire

// ----- tb/tb_simon_128_block_cipher.sv -----
// Self-checking testbench for the SIMON 128-bit block cipher core.
`default_nettype none

module tb_simon_128_block_cipher;
    import simon_pkg::*;

    localparam int     N_PHASES      = 15;
    localparam int     PER_PHASE     = 60;
    localparam int     SETTLE_CYCLES = 300;
    localparam longint CYCLE_LIMIT   = 1_500_000;
    // percent of commands that the sender precedes with an idle gap
    localparam int     IDLE_NONE     = 0;
    localparam int     IDLE_HEAVY    = 62;
    localparam int     IDLE_LIGHT    = 6;
    // key size code 3 behaves as a 256-bit key
    localparam logic [1:0] KS_256_ALIAS = 2'd3;
    localparam logic [2:0] CFG_IDX_TOP  = 3'd7;
    localparam t_word      ALL_ONES     = '1;

    // Predicts each cipher result and holds the ones still outstanding.
    class simon_block_scoreboard;
        logic [1:0] key_mode;
        t_word      key_regs[4];
        t_word      sched[RK_DEPTH];
        bit         sched_valid;
        int         n_rounds;
        t_simon_out expected_blocks[$];
        int         errors;

        function new();
            key_mode    = KS_128;
            key_regs    = '{default: '0};
            sched       = '{default: '0};
            sched_valid = 0;
            n_rounds    = ROUNDS_128;
            errors      = 0;
        endfunction

        task report(string what, t_word got, t_word want);
            $display("[%0t] mismatch on %s: got %h want %h", $time, what, got, want);
            errors++;
        endtask

        function t_word ror(t_word v, int n);
            return (v >> n) | (v << (64 - n));
        endfunction

        // round function: (rol1 & rol8) ^ rol2
        function t_word feistel_f(t_word v);
            return (ror(v, 63) & ror(v, 56)) ^ ror(v, 62);
        endfunction

        function void reg_write(logic [2:0] idx, t_word data);
            case (idx)
                CFG_MODE: key_mode = data[1:0];
                CFG_KEY0: key_regs[0] = data;
                CFG_KEY1: key_regs[1] = data;
                CFG_KEY2: key_regs[2] = data;
                CFG_KEY3: key_regs[3] = data;
                default:  return;
            endcase
            sched_valid = 0;
        endfunction

        // key schedule into the round-key table
        function void expand_schedule();
            int          nkw;
            logic [71:0] zseq;
            t_word       tmp;
            case (key_mode)
                KS_128: begin
                    nkw = 2; n_rounds = ROUNDS_128; zseq = Z_SEQ_128;
                end
                KS_192: begin
                    nkw = 3; n_rounds = ROUNDS_192; zseq = Z_SEQ_192;
                end
                default: begin
                    nkw = 4; n_rounds = ROUNDS_256; zseq = Z_SEQ_256;
                end
            endcase
            for (int i = 0; i < nkw; i++)
                sched[i] = key_regs[nkw - 1 - i];
            for (int i = nkw; i < n_rounds; i++) begin
                tmp = RK_CONST ^ {63'd0, zseq[i - nkw]} ^ sched[i - nkw]
                      ^ ror(sched[i - 1], 3) ^ ror(sched[i - 1], 4);
                if (nkw == 4)
                    tmp ^= sched[i - 3] ^ ror(sched[i - 3], 1);
                sched[i] = tmp;
            end
            sched_valid = 1;
        endfunction

        function t_simon_out cipher_block(t_simon_in w);
            t_word      x, y, t;
            t_simon_out r;
            if (!sched_valid)
                expand_schedule();
            x = w.block_x;
            y = w.block_y;
            if (w.cmd == CMD_ENC) begin
                for (int i = 0; i < n_rounds; i++) begin
                    t = x;
                    x = y ^ feistel_f(x) ^ sched[i];
                    y = t;
                end
            end else begin
                for (int i = n_rounds; i > 0; i--) begin
                    t = y;
                    y = x ^ feistel_f(y) ^ sched[i - 1];
                    x = t;
                end
            end
            r.out_x = x;
            r.out_y = y;
            return r;
        endfunction

        function void note_command(t_simon_in w);
            expected_blocks.push_back(cipher_block(w));
        endfunction

        task check_block(t_simon_out got);
            t_simon_out want;
            if (expected_blocks.size() == 0) begin
                report("unexpected word out_x", got.out_x, '0);
                return;
            end
            want = expected_blocks.pop_front();
            if (got.out_x !== want.out_x)
                report("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y)
                report("out_y", got.out_y, want.out_y);
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_simon_in  i_blk;
    logic       o_res_valid;
    t_simon_out o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    t_word      i_cfg_data;

    simon_block_scoreboard sb;
    longint                cycle_cnt;
    int                    idle_pct;

    simon_128_block_cipher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_blk       (i_blk),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid)
            sb.check_block(o_res);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // biased data word: mostly random, sometimes an extreme
    function automatic t_word rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return t_word'(1) << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_simon_in rand_cmd();
        t_simon_in w;
        w.cmd     = $urandom_range(1) ? CMD_DEC : CMD_ENC;
        w.block_x = rand_word();
        w.block_y = rand_word();
        return w;
    endfunction

    function automatic t_simon_in mk_cmd(logic c, t_word x, t_word y);
        t_simon_in w;
        w.cmd     = c;
        w.block_x = x;
        w.block_y = y;
        return w;
    endfunction

    // one configuration word; called at a falling edge
    task automatic cfg_write(input logic [2:0] idx, input t_word data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = {$urandom, $urandom};
    endtask

    // hold the sender off until every result is back and the core is idle
    task automatic drain();
        start = 1'b0;
        while (sb.expected_blocks.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    // one command word; start stays high on return so words can go back to back
    task automatic send_cmd(input t_simon_in w);
        i_blk = w;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_command(w);
        @(negedge i_clk);
    endtask

    // command word preceded by a random gap at the current idle rate
    task automatic send_paced(input t_simon_in w);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(150, 1) : $urandom_range(4, 1);
        if (gap > 0) begin
            start = 1'b0;
            i_blk = rand_cmd();
            repeat (gap) @(negedge i_clk);
        end
        send_cmd(w);
    endtask

    task automatic directed_part();
        // reset key state: all-zero 128-bit key, expanded on first use
        send_cmd(mk_cmd(CMD_ENC, '0, '0));
        send_cmd(mk_cmd(CMD_DEC, '0, '0));
        send_cmd(mk_cmd(CMD_ENC, ALL_ONES, ALL_ONES));
        send_cmd(mk_cmd(CMD_DEC, ALL_ONES, ALL_ONES));
        send_cmd(mk_cmd(CMD_ENC, t_word'(1) << 63, t_word'(1)));
        send_cmd(mk_cmd(CMD_DEC, t_word'(1), t_word'(1) << 63));

        // 192-bit key: odd round count
        drain();
        cfg_write(CFG_MODE, KS_192);
        cfg_write(CFG_KEY0, rand_word());
        cfg_write(CFG_KEY1, rand_word());
        cfg_write(CFG_KEY2, rand_word());
        send_cmd(mk_cmd(CMD_ENC, {$urandom, $urandom}, {$urandom, $urandom}));
        send_cmd(mk_cmd(CMD_DEC, {$urandom, $urandom}, {$urandom, $urandom}));
        send_cmd(mk_cmd(CMD_ENC, ALL_ONES, '0));

        // 256-bit key, all ones
        drain();
        cfg_write(CFG_MODE, KS_256);
        cfg_write(CFG_KEY0, ALL_ONES);
        cfg_write(CFG_KEY1, ALL_ONES);
        cfg_write(CFG_KEY2, ALL_ONES);
        cfg_write(CFG_KEY3, ALL_ONES);
        send_cmd(mk_cmd(CMD_ENC, '0, ALL_ONES));
        send_cmd(mk_cmd(CMD_DEC, {$urandom, $urandom}, {$urandom, $urandom}));

        // size code 3 acts as 256
        drain();
        cfg_write(CFG_MODE, KS_256_ALIAS);
        send_cmd(mk_cmd(CMD_ENC, {$urandom, $urandom}, {$urandom, $urandom}));
        send_cmd(mk_cmd(CMD_DEC, {$urandom, $urandom}, {$urandom, $urandom}));

        // out-of-range register index is dropped
        drain();
        cfg_write(3'($urandom_range(CFG_IDX_TOP, CFG_KEY3 + 1)), {$urandom, $urandom});
        send_cmd(mk_cmd(CMD_ENC, {$urandom, $urandom}, {$urandom, $urandom}));

        // one key word changed alone still forces a new schedule
        drain();
        cfg_write(CFG_KEY1, {$urandom, $urandom});
        send_cmd(mk_cmd(CMD_ENC, {$urandom, $urandom}, {$urandom, $urandom}));
        send_cmd(mk_cmd(CMD_DEC, {$urandom, $urandom}, {$urandom, $urandom}));

        // back to 128 with fresh keys
        drain();
        cfg_write(CFG_MODE, KS_128);
        cfg_write(CFG_KEY0, {$urandom, $urandom});
        cfg_write(CFG_KEY1, {$urandom, $urandom});
        send_cmd(mk_cmd(CMD_ENC, {$urandom, $urandom}, {$urandom, $urandom}));
        send_cmd(mk_cmd(CMD_DEC, {$urandom, $urandom}, {$urandom, $urandom}));
    endtask

    // per-phase key setup, extremes in the first two phases
    task automatic phase_config(input int ph);
        logic [1:0] mode;
        t_word      kval;
        drain();
        if (ph == 0)
            mode = KS_128;
        else if (ph == 1)
            mode = KS_256;
        else
            mode = 2'($urandom_range(3));
        cfg_write(CFG_MODE, mode);
        for (int k = 0; k < 4; k++) begin
            if (ph == 0)
                kval = '0;
            else if (ph == 1)
                kval = ALL_ONES;
            else
                kval = rand_word();
            if (ph < 2 || $urandom_range(4) != 0)
                cfg_write(3'(CFG_KEY0 + k), kval);
        end
        if ($urandom_range(3) == 0)
            cfg_write(3'($urandom_range(CFG_IDX_TOP, CFG_KEY3 + 1)), {$urandom, $urandom});
    endtask

    initial begin
        t_simon_in w;
        sb          = new();
        cycle_cnt   = 0;
        idle_pct    = IDLE_NONE;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_blk       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data  = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_part();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            phase_config(ph);
            case (ph % 3)
                0:       idle_pct = IDLE_NONE;
                1:       idle_pct = IDLE_HEAVY;
                default: idle_pct = IDLE_LIGHT;
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                // now and then let the core drain completely mid-phase
                if ($urandom_range(39) == 0)
                    drain();
                w = rand_cmd();
                send_paced(w);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_blocks.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/simon_pkg.sv
sv/simon_128_block_cipher.sv
tb/tb_simon_128_block_cipher.sv
